FILE: rtl/mcc_pkg.sv
package mcc_pkg;

    // serial multiplier geometry
    localparam int MCAND_W = 27;
    localparam int DIGIT_W = 8;
    localparam int PROD_W  = MCAND_W + DIGIT_W;

    // input function codes
    localparam logic [1:0] FUNC_MEAS   = 2'd0;
    localparam logic [1:0] FUNC_REF    = 2'd1;
    localparam logic [1:0] FUNC_RELOAD = 2'd2;

    // result mode codes
    localparam logic [1:0] MODE_ILLUM  = 2'd0;
    localparam logic [1:0] MODE_CHAN   = 2'd1;
    localparam logic [1:0] MODE_RELOAD = 2'd2;

    // register indexes
    localparam logic [2:0] REG_THR_LUMA  = 3'd0;
    localparam logic [2:0] REG_GAIN_LUMA = 3'd1;
    localparam logic [2:0] REG_THR_CHAN  = 3'd2;
    localparam logic [2:0] REG_GAIN_RED  = 3'd3;
    localparam logic [2:0] REG_GAIN_GRN  = 3'd4;
    localparam logic [2:0] REG_GAIN_BLU  = 3'd5;
    localparam logic [2:0] REG_INIT_BG   = 3'd6;
    localparam logic [2:0] REG_INIT_YP   = 3'd7;

    typedef struct packed {
        logic                      start;
        logic signed [MCAND_W-1:0] mcand;
        logic [DIGIT_W-1:0]        mplier;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] product;
    } t_mul_rsp;

endpackage

FILE: rtl/mcc_mul.sv
module mcc_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcc_pkg::t_mul_req i_req,
    output mcc_pkg::t_mul_rsp o_rsp
);
    import mcc_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [2:0]               r_cnt;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] r_mc;
    logic [DIGIT_W-1:0]       r_mp;

    // one multiplier bit per cycle, lsb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_mc   <= {{DIGIT_W{i_req.mcand[MCAND_W-1]}}, i_req.mcand};
                r_mp   <= i_req.mplier;
            end else if (r_busy) begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc  <= r_mc <<< 1;
                r_mp  <= r_mp >> 1;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'(DIGIT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done    = r_done;
        o_rsp.product = r_acc;
    end

`ifndef NO_ASSERTIONS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiply started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start && r_cnt == 3'(DIGIT_W - 1)) |=> (r_done && !r_busy))
        else $error("multiply did not finish after last digit");
`endif

endmodule

FILE: rtl/marker_color_calibrator_top.sv
// a reference is stored as it is taken; a reload gives its four results in slot order, each
//   as soon as the output side is free; a measurement passes decide, a luma product in
//   illuminance mode, a product per channel (in channel mode only past its threshold) and
//   emit, held by any output stall; each product has issue, start, 8 bit-serial steps, done
// throughput: one item at a time; the next is taken once the result is in the output register
// reset: synchronous active-low, loads register defaults, clears references and drives
module marker_color_calibrator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [1:0]  i_color,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_luma_in,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_color_out,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [1:0]  o_mode_out,
    output logic        o_last,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    import mcc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_KWAIT,
        S_CHAN,
        S_CWAIT,
        S_EMIT,
        S_RELOAD
    } t_state;

    t_state r_state;

    // configuration registers
    logic [7:0]  r_thr_luma;
    logic [15:0] r_gain_luma;
    logic [7:0]  r_thr_chan;
    logic [15:0] r_gain [3];
    logic [47:0] r_init_bg;
    logic [47:0] r_init_yp;

    // per-slot state: reference {r,g,b,luma} and drive {r,g,b}
    logic [31:0] r_ref [4];
    logic [23:0] r_drv [4];

    // working copy of the item in progress
    logic [1:0]               r_slot;
    logic [31:0]              r_cur_word;
    logic [31:0]              r_ref_word;
    logic [23:0]              r_drv_word;
    logic [1:0]               r_mode;
    logic [1:0]               r_ch;
    logic signed [MCAND_W-1:0] r_k;
    logic [7:0]               r_res [3];

    // output register
    logic       r_out_valid;
    logic [1:0] r_color_out;
    logic [7:0] r_red_out;
    logic [7:0] r_green_out;
    logic [7:0] r_blue_out;
    logic [1:0] r_mode_out;
    logic       r_last;

    t_mul_req r_mul_req;
    t_mul_rsp w_mul_rsp;

    logic w_in_xfer;
    logic w_out_free;

    // selected channel of the item in progress
    logic [7:0]  w_ref_c;
    logic [7:0]  w_cur_c;
    logic [7:0]  w_drv_c;
    logic [15:0] w_gain_c;
    logic [8:0]  w_e;
    logic [7:0]  w_e_mag;
    logic [8:0]  w_el;
    logic [7:0]  w_el_mag;
    logic [23:0] w_init_drv;

    logic signed [PROD_W-1:0] w_p_chan;
    logic signed [PROD_W-1:0] w_p_luma;
    logic signed [PROD_W-1:0] w_chan_v;
    logic signed [PROD_W-1:0] w_k_full;
    logic [7:0]               w_res_new;

    // floor of v / 2^frac, clamped to 0..255
    function automatic logic [7:0] f_clamp(input logic signed [PROD_W-1:0] v,
                                           input logic sh16);
        logic signed [PROD_W-1:0] q;
        logic [7:0]               r;
        q = sh16 ? (v >>> 16) : (v >>> 12);
        if (v[PROD_W-1]) begin
            r = 8'd0;
        end else if (q > PROD_W'(255)) begin
            r = 8'hFF;
        end else begin
            r = q[7:0];
        end
        return r;
    endfunction

    mcc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    // output register can take a new result this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (r_ch)
            2'd0: begin
                w_ref_c  = r_ref_word[31:24];
                w_cur_c  = r_cur_word[31:24];
                w_drv_c  = r_drv_word[23:16];
                w_gain_c = r_gain[0];
            end
            2'd1: begin
                w_ref_c  = r_ref_word[23:16];
                w_cur_c  = r_cur_word[23:16];
                w_drv_c  = r_drv_word[15:8];
                w_gain_c = r_gain[1];
            end
            default: begin
                w_ref_c  = r_ref_word[15:8];
                w_cur_c  = r_cur_word[15:8];
                w_drv_c  = r_drv_word[7:0];
                w_gain_c = r_gain[2];
            end
        endcase
    end

    // reload order: blue, yellow, pink, green slots
    always_comb begin
        case (r_ch)
            2'd0:    w_init_drv = r_init_bg[47:24];
            2'd1:    w_init_drv = r_init_yp[47:24];
            2'd2:    w_init_drv = r_init_yp[23:0];
            default: w_init_drv = r_init_bg[23:0];
        endcase
    end

    // errors as reference minus measured, 9-bit two's complement
    assign w_e      = {1'b0, w_ref_c} - {1'b0, w_cur_c};
    assign w_e_mag  = w_e[8] ? 8'(-w_e) : w_e[7:0];
    assign w_el     = {1'b0, r_ref_word[7:0]} - {1'b0, r_cur_word[7:0]};
    assign w_el_mag = w_el[8] ? 8'(-w_el) : w_el[7:0];

    // multiplier works on magnitudes, sign applied here
    assign w_p_chan = w_e[8] ? -w_mul_rsp.product : w_mul_rsp.product;
    assign w_p_luma = w_el[8] ? -w_mul_rsp.product : w_mul_rsp.product;
    assign w_chan_v = $signed({15'd0, w_drv_c, 12'd0}) + w_p_chan;
    // illuminance factor 1 + gain*err in q.16
    assign w_k_full = PROD_W'(65536) + w_p_luma;

    assign w_res_new = (r_mode == MODE_ILLUM) ? f_clamp(w_mul_rsp.product, 1'b1)
                                              : f_clamp(w_chan_v, 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mul_req   <= '0;
            r_ch        <= '0;
            r_thr_luma  <= 8'd10;
            r_gain_luma <= 16'd66;
            r_thr_chan  <= 8'd10;
            r_gain[0]   <= 16'd410;
            r_gain[1]   <= 16'd410;
            r_gain[2]   <= 16'd410;
            r_init_bg   <= '0;
            r_init_yp   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_ref[i] <= '0;
                r_drv[i] <= '0;
            end
        end else begin
            r_mul_req.start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THR_LUMA:  r_thr_luma  <= i_cfg_data[7:0];
                    REG_GAIN_LUMA: r_gain_luma <= i_cfg_data[15:0];
                    REG_THR_CHAN:  r_thr_chan  <= i_cfg_data[7:0];
                    REG_GAIN_RED:  r_gain[0]   <= i_cfg_data[15:0];
                    REG_GAIN_GRN:  r_gain[1]   <= i_cfg_data[15:0];
                    REG_GAIN_BLU:  r_gain[2]   <= i_cfg_data[15:0];
                    REG_INIT_BG:   r_init_bg   <= i_cfg_data;
                    REG_INIT_YP:   r_init_yp   <= i_cfg_data;
                    default:       ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_slot     <= i_color;
                        r_cur_word <= {i_red_in, i_green_in, i_blue_in, i_luma_in};
                        r_ref_word <= r_ref[i_color];
                        r_drv_word <= r_drv[i_color];
                        r_ch       <= '0;
                        case (i_func)
                            FUNC_MEAS: begin
                                // no stored reference luma: nothing to correct
                                if (r_ref[i_color][7:0] != 8'd0) begin
                                    r_state <= S_DECIDE;
                                end
                            end
                            FUNC_REF: begin
                                r_ref[i_color] <= {i_red_in, i_green_in, i_blue_in, i_luma_in};
                            end
                            FUNC_RELOAD: begin
                                r_drv[0] <= r_init_bg[47:24];
                                r_drv[1] <= r_init_yp[47:24];
                                r_drv[2] <= r_init_yp[23:0];
                                r_drv[3] <= r_init_bg[23:0];
                                r_state  <= S_RELOAD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DECIDE: begin
                    if (w_el_mag > r_thr_luma) begin
                        r_mode           <= MODE_ILLUM;
                        r_mul_req.start  <= 1'b1;
                        r_mul_req.mcand  <= MCAND_W'(r_gain_luma);
                        r_mul_req.mplier <= w_el_mag;
                        r_state          <= S_KWAIT;
                    end else begin
                        r_mode  <= MODE_CHAN;
                        r_state <= S_CHAN;
                    end
                end
                S_KWAIT: begin
                    if (w_mul_rsp.done) begin
                        r_k     <= w_k_full[MCAND_W-1:0];
                        r_state <= S_CHAN;
                    end
                end
                S_CHAN: begin
                    if (r_mode == MODE_ILLUM) begin
                        r_mul_req.start  <= 1'b1;
                        r_mul_req.mcand  <= r_k;
                        r_mul_req.mplier <= w_drv_c;
                        r_state          <= S_CWAIT;
                    end else if (w_e_mag > r_thr_chan) begin
                        r_mul_req.start  <= 1'b1;
                        r_mul_req.mcand  <= MCAND_W'(w_gain_c);
                        r_mul_req.mplier <= w_e_mag;
                        r_state          <= S_CWAIT;
                    end else begin
                        // channel within threshold keeps its drive
                        r_res[r_ch] <= w_drv_c;
                        if (r_ch == 2'd2) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_ch <= r_ch + 2'd1;
                        end
                    end
                end
                S_CWAIT: begin
                    if (w_mul_rsp.done) begin
                        r_res[r_ch] <= w_res_new;
                        if (r_ch == 2'd2) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_state <= S_CHAN;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_color_out   <= r_slot;
                        r_red_out     <= r_res[0];
                        r_green_out   <= r_res[1];
                        r_blue_out    <= r_res[2];
                        r_mode_out    <= r_mode;
                        r_last        <= 1'b1;
                        r_drv[r_slot] <= {r_res[0], r_res[1], r_res[2]};
                        r_state       <= S_IDLE;
                    end
                end
                S_RELOAD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_color_out <= r_ch;
                        r_red_out   <= w_init_drv[23:16];
                        r_green_out <= w_init_drv[15:8];
                        r_blue_out  <= w_init_drv[7:0];
                        r_mode_out  <= MODE_RELOAD;
                        r_last      <= (r_ch == 2'd3);
                        r_ch        <= r_ch + 2'd1;
                        if (r_ch == 2'd3) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_color_out = r_color_out;
    assign o_red_out   = r_red_out;
    assign o_green_out = r_green_out;
    assign o_blue_out  = r_blue_out;
    assign o_mode_out  = r_mode_out;
    assign o_last      = r_last;

`ifndef NO_ASSERTIONS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == S_KWAIT || r_state == S_CWAIT))
        else $error("multiplier result arrived outside a wait state");
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHAN || r_state == S_CWAIT) |-> (r_ch != 2'd3))
        else $error("channel index out of range");
    a_reload_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_mode_out == MODE_RELOAD && r_last) |-> (r_color_out == 2'd3))
        else $error("reload ended on wrong slot");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && (r_state == S_EMIT || r_state == S_RELOAD))
        |=> ($stable(r_color_out) && r_out_valid))
        else $error("pending result overwritten");
`endif

endmodule

FILE: bench/drive_checker.sv
`timescale 1ns / 1ps

module drive_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_func,
    input  logic [1:0]  i_color,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_luma_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_color_out,
    input  logic [7:0]  i_red_out,
    input  logic [7:0]  i_green_out,
    input  logic [7:0]  i_blue_out,
    input  logic [1:0]  i_mode_out,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import mcc_pkg::*;

    typedef struct packed {
        logic [1:0] color;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] mode;
        logic       last;
    } t_drive_report;

    logic [7:0]  thr_luma;
    logic [15:0] gain_luma;
    logic [7:0]  thr_chan;
    logic [15:0] chan_gain [3];
    logic [47:0] init_bg;
    logic [47:0] init_yp;

    // per slot: red, green, blue, luma
    logic [7:0] slot_ref [4][4];
    // per slot: red, green, blue
    logic [7:0] drive_now [4][3];

    t_drive_report reports_due [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns drive check: %s", $time, msg);
        o_errors++;
    endtask

    function automatic logic [7:0] clamp_shift(input longint v, input int frac);
        longint q;
        if (v < 0) return 8'd0;
        q = v >>> frac;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    task automatic set_drive(input int slot, input logic [23:0] w);
        drive_now[slot][0] = w[23:16];
        drive_now[slot][1] = w[15:8];
        drive_now[slot][2] = w[7:0];
    endtask

    task automatic load_drives();
        set_drive(0, init_bg[47:24]);
        set_drive(3, init_bg[23:0]);
        set_drive(1, init_yp[47:24]);
        set_drive(2, init_yp[23:0]);
    endtask

    task automatic write_reg();
        case (i_cfg_idx)
            REG_THR_LUMA:  thr_luma     = i_cfg_data[7:0];
            REG_GAIN_LUMA: gain_luma    = i_cfg_data[15:0];
            REG_THR_CHAN:  thr_chan     = i_cfg_data[7:0];
            REG_GAIN_RED:  chan_gain[0] = i_cfg_data[15:0];
            REG_GAIN_GRN:  chan_gain[1] = i_cfg_data[15:0];
            REG_GAIN_BLU:  chan_gain[2] = i_cfg_data[15:0];
            REG_INIT_BG:   init_bg      = i_cfg_data;
            REG_INIT_YP:   init_yp      = i_cfg_data;
            default: ;
        endcase
    endtask

    task automatic accept_item();
        t_drive_report rpt;
        logic [7:0]    meas [3];
        int            slot;
        int            err;
        int            mag;
        int            e;
        longint        drv_v;
        longint        g;
        slot    = i_color;
        meas[0] = i_red_in;
        meas[1] = i_green_in;
        meas[2] = i_blue_in;
        case (i_func)
            FUNC_REF: begin
                slot_ref[slot][0] = i_red_in;
                slot_ref[slot][1] = i_green_in;
                slot_ref[slot][2] = i_blue_in;
                slot_ref[slot][3] = i_luma_in;
            end
            FUNC_RELOAD: begin
                load_drives();
                for (int s = 0; s < 4; s++) begin
                    rpt.color = s[1:0];
                    rpt.red   = drive_now[s][0];
                    rpt.green = drive_now[s][1];
                    rpt.blue  = drive_now[s][2];
                    rpt.mode  = MODE_RELOAD;
                    rpt.last  = (s == 3);
                    reports_due.push_back(rpt);
                end
            end
            FUNC_MEAS: begin
                // no reference luma for the slot: nothing happens
                if (slot_ref[slot][3] != 8'd0) begin
                    err = int'(slot_ref[slot][3]) - int'(i_luma_in);
                    mag = (err < 0) ? -err : err;
                    if (mag > int'(thr_luma)) begin
                        rpt.mode = MODE_ILLUM;
                        g = gain_luma;
                        for (int c = 0; c < 3; c++) begin
                            drv_v = drive_now[slot][c];
                            drive_now[slot][c] =
                                clamp_shift(drv_v * 65536 + g * err * drv_v, 16);
                        end
                    end else begin
                        rpt.mode = MODE_CHAN;
                        for (int c = 0; c < 3; c++) begin
                            e     = int'(slot_ref[slot][c]) - int'(meas[c]);
                            mag   = (e < 0) ? -e : e;
                            drv_v = drive_now[slot][c];
                            g     = chan_gain[c];
                            if (mag > int'(thr_chan))
                                drive_now[slot][c] = clamp_shift(drv_v * 4096 + g * e, 12);
                        end
                    end
                    rpt.color = i_color;
                    rpt.red   = drive_now[slot][0];
                    rpt.green = drive_now[slot][1];
                    rpt.blue  = drive_now[slot][2];
                    rpt.last  = 1'b1;
                    reports_due.push_back(rpt);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_report();
        t_drive_report want;
        if (reports_due.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
            return;
        end
        want = reports_due.pop_front();
        if (i_color_out !== want.color)
            report_mismatch($sformatf("color_out %0d, want %0d", i_color_out, want.color));
        if (i_red_out !== want.red)
            report_mismatch($sformatf("slot %0d red_out %0d, want %0d",
                                      want.color, i_red_out, want.red));
        if (i_green_out !== want.green)
            report_mismatch($sformatf("slot %0d green_out %0d, want %0d",
                                      want.color, i_green_out, want.green));
        if (i_blue_out !== want.blue)
            report_mismatch($sformatf("slot %0d blue_out %0d, want %0d",
                                      want.color, i_blue_out, want.blue));
        if (i_mode_out !== want.mode)
            report_mismatch($sformatf("slot %0d mode_out %0d, want %0d",
                                      want.color, i_mode_out, want.mode));
        if (i_last !== want.last)
            report_mismatch($sformatf("slot %0d last %0b, want %0b",
                                      want.color, i_last, want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors     = 0;
            thr_luma     = 8'd10;
            gain_luma    = 16'd66;
            thr_chan     = 8'd10;
            chan_gain[0] = 16'd410;
            chan_gain[1] = 16'd410;
            chan_gain[2] = 16'd410;
            init_bg      = '0;
            init_yp      = '0;
            for (int s = 0; s < 4; s++)
                for (int k = 0; k < 4; k++)
                    slot_ref[s][k] = 8'd0;
            load_drives();
            reports_due.delete();
        end else begin
            if (i_cfg_we)
                write_reg();
            // input first so a same-edge result still finds its expectation
            if (i_in_valid && i_in_ready)
                accept_item();
            if (i_out_valid && i_out_ready)
                check_report();
        end
        o_pending = reports_due.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import mcc_pkg::*;

    // func code the block has no use for
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // room for the longest measurement, with some slack
    localparam int SETTLE_CYCLES = 64;
    // long receiver hold-off to back the block up into its input
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = '0;
    logic [1:0]  color = '0;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic [7:0]  luma_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  color_out;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [1:0]  mode_out;
    logic        last;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [47:0] cfg_data = '0;

    int   errors;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_rx = 1'b0;
    logic pressure_go = 1'b0;

    // references as sent, used only to aim measurements near them
    logic [7:0] ref_sent [4][4];

    always #5 clk = ~clk;

    marker_color_calibrator_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_func      (func),
        .i_color     (color),
        .i_red_in    (red_in),
        .i_green_in  (green_in),
        .i_blue_in   (blue_in),
        .i_luma_in   (luma_in),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_color_out (color_out),
        .o_red_out   (red_out),
        .o_green_out (green_out),
        .o_blue_out  (blue_out),
        .o_mode_out  (mode_out),
        .o_last      (last),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    drive_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_func      (func),
        .i_color     (color),
        .i_red_in    (red_in),
        .i_green_in  (green_in),
        .i_blue_in   (blue_in),
        .i_luma_in   (luma_in),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_color_out (color_out),
        .i_red_out   (red_out),
        .i_green_out (green_out),
        .i_blue_out  (blue_out),
        .i_mode_out  (mode_out),
        .i_last      (last),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // result side: random stalls, forced low during the hold-off
    always @(negedge clk) begin
        out_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
    end

    // hold-off counted here while the sender keeps offering items
    initial begin
        wait (pressure_go);
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    end

    // one item transfer: optional gaps first, then valid held until ready
    task automatic send_item(input logic [1:0] f, input logic [1:0] c, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b, input logic [7:0] l);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        color    <= c;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        luma_in  <= l;
        if (f == FUNC_REF) begin
            ref_sent[c][0] = r;
            ref_sent[c][1] = g;
            ref_sent[c][2] = b;
            ref_sent[c][3] = l;
        end
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // register write; the caller drops the write enable after the last one
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [7:0] t_luma, input logic [15:0] g_luma,
                              input logic [7:0] t_chan, input logic [15:0] g_red,
                              input logic [15:0] g_grn, input logic [15:0] g_blu,
                              input logic [47:0] bg, input logic [47:0] yp);
        write_reg(REG_THR_LUMA,  48'(t_luma));
        write_reg(REG_GAIN_LUMA, 48'(g_luma));
        write_reg(REG_THR_CHAN,  48'(t_chan));
        write_reg(REG_GAIN_RED,  48'(g_red));
        write_reg(REG_GAIN_GRN,  48'(g_grn));
        write_reg(REG_GAIN_BLU,  48'(g_blu));
        write_reg(REG_INIT_BG,   bg);
        write_reg(REG_INIT_YP,   yp);
        cfg_we <= 1'b0;
    endtask

    // wait for every expected result, then let a silent measurement finish
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] nudge(input logic [7:0] base, input int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // mostly measurements, near the stored reference or noise; also references, reloads, unused codes
    task automatic random_item();
        int         pick;
        logic [1:0] s;
        logic [7:0] l;
        pick = $urandom_range(99);
        s    = 2'($urandom_range(3));
        if (pick < 14) begin
            l = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            send_item(FUNC_REF, s, 8'($urandom), 8'($urandom), 8'($urandom), l);
        end else if (pick < 20) begin
            send_item(FUNC_RELOAD, s, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 23) begin
            send_item(FUNC_UNUSED, s, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 70) begin
            send_item(FUNC_MEAS, s, nudge(ref_sent[s][0], 40), nudge(ref_sent[s][1], 40),
                      nudge(ref_sent[s][2], 40), nudge(ref_sent[s][3], 12));
        end else begin
            send_item(FUNC_MEAS, s, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        for (int s = 0; s < 4; s++)
            for (int k = 0; k < 4; k++)
                ref_sent[s][k] = 8'd0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed, reset defaults
        // reload right after reset reports all-zero drives, last on slot 3
        send_item(FUNC_RELOAD, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // no reference stored yet: silent
        send_item(FUNC_MEAS, 2'd1, 8'd10, 8'd20, 8'd30, 8'd40);
        // unused func is ignored
        send_item(FUNC_UNUSED, 2'd2, 8'hff, 8'hff, 8'hff, 8'hff);
        drain();

        set_config(8'd10, 16'd66, 8'd10, 16'd410, 16'd410, 16'd410,
                   48'hffffff_808080, 48'h000000_7f80ff);
        send_item(FUNC_RELOAD, 2'd3, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_REF, 2'd0, 8'd200, 8'd100, 8'd50, 8'd128);
        // matches the reference: channel mode, nothing moves
        send_item(FUNC_MEAS, 2'd0, 8'd200, 8'd100, 8'd50, 8'd128);
        // errors of both signs plus one under threshold
        send_item(FUNC_MEAS, 2'd0, 8'd0, 8'd255, 8'd45, 8'd125);
        // luma far off in both directions: illuminance scaling
        send_item(FUNC_MEAS, 2'd0, 8'd200, 8'd100, 8'd50, 8'd0);
        send_item(FUNC_MEAS, 2'd0, 8'd200, 8'd100, 8'd50, 8'd255);
        send_item(FUNC_REF, 2'd3, 8'd0, 8'd0, 8'd0, 8'd255);
        send_item(FUNC_MEAS, 2'd3, 8'd255, 8'd255, 8'd255, 8'd250);
        // zero drive stays zero under scaling
        send_item(FUNC_REF, 2'd1, 8'd255, 8'd255, 8'd255, 8'd255);
        send_item(FUNC_MEAS, 2'd1, 8'd0, 8'd0, 8'd0, 8'd0);
        // smallest nonzero reference luma
        send_item(FUNC_REF, 2'd2, 8'd128, 8'd128, 8'd128, 8'd1);
        send_item(FUNC_MEAS, 2'd2, 8'd128, 8'd0, 8'd255, 8'd1);
        drain();

        // extreme gains, zero channel threshold: outputs pinned at both ends
        set_config(8'd255, 16'hffff, 8'd0, 16'hffff, 16'hffff, 16'hffff,
                   48'h000000_ffffff, 48'hffffff_000000);
        send_item(FUNC_RELOAD, 2'd1, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_MEAS, 2'd2, 8'd0, 8'd255, 8'd128, 8'd0);
        drain();

        // zero luma threshold, full luma gain, channels effectively off
        set_config(8'd0, 16'hffff, 8'd255, 16'd0, 16'd0, 16'd0,
                   48'h123456_abcdef, 48'h89abcd_fedcba);
        send_item(FUNC_RELOAD, 2'd2, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_MEAS, 2'd0, 8'd1, 8'd2, 8'd3, 8'd127);
        // luma equal: channel mode with no channel past its threshold
        send_item(FUNC_MEAS, 2'd0, 8'd0, 8'd0, 8'd0, 8'd128);
        send_item(FUNC_MEAS, 2'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        // overwriting a reference with zero luma silences the slot again
        send_item(FUNC_REF, 2'd0, 8'd9, 8'd9, 8'd9, 8'd0);
        send_item(FUNC_MEAS, 2'd0, 8'd200, 8'd100, 8'd50, 8'd128);
        drain();

        // --- random phases: sender mostly busy, then receiver, then both
        for (int ph = 0; ph < 3; ph++) begin
            set_config(8'($urandom_range(0, 40)), 16'($urandom), 8'($urandom_range(0, 40)),
                       16'($urandom_range(0, 16383)), 16'($urandom_range(0, 16383)),
                       16'($urandom_range(0, 16383)),
                       48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            case (ph)
                0: begin
                    tx_idle_pct = 13;
                    rx_idle_pct = 87;
                end
                1: begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 13;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // receiver holds off while reloads pile up behind it
                    pressure_go = 1'b1;
                end
            endcase
            send_item(FUNC_RELOAD, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0);
            if (ph == 2)
                repeat (3) send_item(FUNC_RELOAD, 2'($urandom), 8'd0, 8'd0, 8'd0, 8'd0);
            for (int s = 0; s < 4; s++)
                send_item(FUNC_REF, 2'(s), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom_range(1, 255)));
            repeat (47) random_item();
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
